@@ rtl/pair_momentum_decomposition_top_defines.svh @@
// assertion macros shared by the pair momentum decomposition design
`ifndef PAIR_MOMENTUM_DECOMPOSITION_TOP_DEFINES_SVH
`define PAIR_MOMENTUM_DECOMPOSITION_TOP_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define PMD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every rising edge out of reset
`define PMD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pmd_pkg.sv @@
// types, constants and the micro-program of the pair momentum decomposition
`timescale 1ns / 1ps

package pmd_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam int ADDR_W = 5;
    localparam int PC_W   = 7;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_NOT_SPACELIKE = 2'd1;
    localparam logic [1:0] STATUS_NEG_QINV     = 2'd2;
    localparam logic [1:0] STATUS_BAD_PT_S     = 2'd3;

    typedef enum logic [3:0] {
        OP_LOAD, OP_ADD, OP_SUB, OP_SHL2, OP_SHR2,
        OP_MUL, OP_DIV, OP_SQRT, OP_OUT, OP_END
    } op_t;

    typedef enum logic [1:0] {
        CHK_NONE, CHK_LE0, CHK_LT0, CHK_EQ0
    } chk_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] ra;
        logic [ADDR_W-1:0] rb;
        chk_t              chk;
        logic [1:0]        code;
    } uword_t;

    // controller to datapath
    typedef struct packed {
        logic              cap_first;
        logic              cap_second;
        logic              rd;
        logic              go;
        op_t               op;
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] ra;
        logic [ADDR_W-1:0] rb;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;
        logic done;
        logic neg;
        logic zero;
    } stat_t;

    localparam logic [PC_W-1:0] PC_END = 7'd94;

    function automatic uword_t mk(op_t op, int d, int a, int b,
                                  chk_t c = CHK_NONE, logic [1:0] code = STATUS_OK);
        uword_t w;
        w.op   = op;
        w.dst  = ADDR_W'(d);
        w.ra   = ADDR_W'(a);
        w.rb   = ADDR_W'(b);
        w.chk  = c;
        w.code = code;
        return w;
    endfunction

    // slots: 0-3 P, 4-7 Q, 8-11 D, 12 s, 13 scratch, 14 P.Q, 15 Q.Q, 16 D.D,
    // 17 P.D, 20 r numerator, 21 q numerator, 22 pt^2, 23 m2, 24 A, 25 B, 26 C
    function automatic uword_t ucode(logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            7'd0:  w = mk(OP_LOAD, 0, 0, 0);
            7'd1:  w = mk(OP_LOAD, 1, 0, 0);
            7'd2:  w = mk(OP_LOAD, 2, 0, 0);
            7'd3:  w = mk(OP_LOAD, 3, 0, 0);
            7'd4:  w = mk(OP_LOAD, 4, 0, 0);
            7'd5:  w = mk(OP_LOAD, 5, 0, 0);
            7'd6:  w = mk(OP_LOAD, 6, 0, 0);
            7'd7:  w = mk(OP_LOAD, 7, 0, 0);
            7'd8:  w = mk(OP_LOAD, 8, 0, 0);
            7'd9:  w = mk(OP_LOAD, 9, 0, 0);
            7'd10: w = mk(OP_LOAD, 10, 0, 0);
            7'd11: w = mk(OP_LOAD, 11, 0, 0);
            // s = P.P
            7'd12: w = mk(OP_MUL, 12, 0, 0);
            7'd13: w = mk(OP_MUL, 13, 1, 1);
            7'd14: w = mk(OP_SUB, 12, 12, 13);
            7'd15: w = mk(OP_MUL, 13, 2, 2);
            7'd16: w = mk(OP_SUB, 12, 12, 13);
            7'd17: w = mk(OP_MUL, 13, 3, 3);
            7'd18: w = mk(OP_SUB, 12, 12, 13, CHK_LE0, STATUS_BAD_PT_S);
            // P.Q
            7'd19: w = mk(OP_MUL, 14, 0, 4);
            7'd20: w = mk(OP_MUL, 13, 1, 5);
            7'd21: w = mk(OP_SUB, 14, 14, 13);
            7'd22: w = mk(OP_MUL, 13, 2, 6);
            7'd23: w = mk(OP_SUB, 14, 14, 13);
            7'd24: w = mk(OP_MUL, 13, 3, 7);
            7'd25: w = mk(OP_SUB, 14, 14, 13);
            // Q.Q
            7'd26: w = mk(OP_MUL, 15, 4, 4);
            7'd27: w = mk(OP_MUL, 13, 5, 5);
            7'd28: w = mk(OP_SUB, 15, 15, 13);
            7'd29: w = mk(OP_MUL, 13, 6, 6);
            7'd30: w = mk(OP_SUB, 15, 15, 13);
            7'd31: w = mk(OP_MUL, 13, 7, 7);
            7'd32: w = mk(OP_SUB, 15, 15, 13);
            // D.D
            7'd33: w = mk(OP_MUL, 16, 8, 8);
            7'd34: w = mk(OP_MUL, 13, 9, 9);
            7'd35: w = mk(OP_SUB, 16, 16, 13);
            7'd36: w = mk(OP_MUL, 13, 10, 10);
            7'd37: w = mk(OP_SUB, 16, 16, 13);
            7'd38: w = mk(OP_MUL, 13, 11, 11);
            7'd39: w = mk(OP_SUB, 16, 16, 13);
            // P.D
            7'd40: w = mk(OP_MUL, 17, 0, 8);
            7'd41: w = mk(OP_MUL, 13, 1, 9);
            7'd42: w = mk(OP_SUB, 17, 17, 13);
            7'd43: w = mk(OP_MUL, 13, 2, 10);
            7'd44: w = mk(OP_SUB, 17, 17, 13);
            7'd45: w = mk(OP_MUL, 13, 3, 11);
            7'd46: w = mk(OP_SUB, 17, 17, 13);
            // separation numerator
            7'd47: w = mk(OP_MUL, 18, 17, 17);
            7'd48: w = mk(OP_MUL, 19, 16, 12);
            7'd49: w = mk(OP_SUB, 20, 18, 19, CHK_LT0, STATUS_NOT_SPACELIKE);
            // qinv numerator
            7'd50: w = mk(OP_MUL, 18, 14, 14);
            7'd51: w = mk(OP_MUL, 19, 15, 12);
            7'd52: w = mk(OP_SUB, 21, 18, 19, CHK_LT0, STATUS_NEG_QINV);
            // pt^2
            7'd53: w = mk(OP_MUL, 22, 1, 1);
            7'd54: w = mk(OP_MUL, 13, 2, 2);
            7'd55: w = mk(OP_ADD, 22, 22, 13, CHK_EQ0, STATUS_BAD_PT_S);
            // m2
            7'd56: w = mk(OP_MUL, 23, 0, 0);
            7'd57: w = mk(OP_MUL, 13, 3, 3);
            7'd58: w = mk(OP_SUB, 23, 23, 13);
            // A, B, C
            7'd59: w = mk(OP_MUL, 24, 1, 6);
            7'd60: w = mk(OP_MUL, 13, 2, 5);
            7'd61: w = mk(OP_SUB, 24, 24, 13);
            7'd62: w = mk(OP_MUL, 25, 0, 7);
            7'd63: w = mk(OP_MUL, 13, 3, 4);
            7'd64: w = mk(OP_SUB, 25, 25, 13);
            7'd65: w = mk(OP_MUL, 26, 1, 5);
            7'd66: w = mk(OP_MUL, 13, 2, 6);
            7'd67: w = mk(OP_ADD, 26, 26, 13);
            // q_long
            7'd68: w = mk(OP_MUL, 27, 25, 25);
            7'd69: w = mk(OP_SHL2, 28, 23, 23);
            7'd70: w = mk(OP_DIV, 29, 27, 28);
            7'd71: w = mk(OP_SQRT, 29, 29, 29);
            7'd72: w = mk(OP_OUT, 0, 29, 25);
            // q_out
            7'd73: w = mk(OP_MUL, 27, 26, 26);
            7'd74: w = mk(OP_MUL, 27, 27, 12);
            7'd75: w = mk(OP_MUL, 28, 28, 22);
            7'd76: w = mk(OP_DIV, 29, 27, 28);
            7'd77: w = mk(OP_SQRT, 29, 29, 29);
            7'd78: w = mk(OP_OUT, 1, 29, 26);
            // q_side
            7'd79: w = mk(OP_MUL, 27, 24, 24);
            7'd80: w = mk(OP_SHL2, 28, 22, 22);
            7'd81: w = mk(OP_DIV, 29, 27, 28);
            7'd82: w = mk(OP_SQRT, 29, 29, 29);
            7'd83: w = mk(OP_OUT, 2, 29, 24);
            // q_invariant
            7'd84: w = mk(OP_SHL2, 28, 12, 12);
            7'd85: w = mk(OP_DIV, 29, 21, 28);
            7'd86: w = mk(OP_SQRT, 29, 29, 29);
            7'd87: w = mk(OP_OUT, 3, 29, 29);
            // r_invariant
            7'd88: w = mk(OP_DIV, 29, 20, 12);
            7'd89: w = mk(OP_SQRT, 29, 29, 29);
            7'd90: w = mk(OP_OUT, 4, 29, 29);
            // k_transverse
            7'd91: w = mk(OP_SHR2, 29, 22, 22);
            7'd92: w = mk(OP_SQRT, 29, 29, 29);
            7'd93: w = mk(OP_OUT, 5, 29, 29);
            default: w = mk(OP_END, 0, 0, 0);
        endcase
        return w;
    endfunction

endpackage

@@ rtl/pmd_datapath.sv @@
// datapath: particle store, operand memory and the shared bit-serial arithmetic unit
`timescale 1ns / 1ps

module pmd_datapath #(
    parameter int VALUE_WIDTH = pmd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [8*VALUE_WIDTH-1:0]      in_data,
    input  pmd_pkg::cmd_t                 cmd,
    output pmd_pkg::stat_t                stat,
    output logic signed [VALUE_WIDTH-1:0] q_long,
    output logic signed [VALUE_WIDTH-1:0] q_out,
    output logic signed [VALUE_WIDTH-1:0] q_side,
    output logic [VALUE_WIDTH-2:0]        q_invariant,
    output logic [VALUE_WIDTH-2:0]        r_invariant,
    output logic [VALUE_WIDTH-2:0]        k_transverse
);
    import pmd_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int BW = 6 * W + 12;
    localparam int CW = $clog2(BW);
    localparam logic [CW-1:0] CNT_FULL = CW'(BW - 1);
    localparam logic [CW-1:0] CNT_HALF = CW'(BW / 2 - 1);
    localparam logic [BW-1:0] SAT_NEG  = BW'(1) << (W - 1);
    localparam logic [BW-1:0] SAT_POS  = SAT_NEG - BW'(1);
    localparam logic [BW-1:0] SQ_ONE   = BW'(1) << (BW - 2);

    logic signed [W-1:0] fp_reg [4];
    logic signed [W-1:0] fx_reg [4];
    logic signed [W-1:0] sp_reg [4];
    logic signed [W-1:0] sx_reg [4];

    logic [BW-1:0] mem [32];
    logic [BW-1:0] a_reg, b_reg, res_reg;
    logic [BW-1:0] x_reg, y_reg, x_next, y_next, iter_res;
    logic [BW:0]   z_reg, z_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg, wr_reg;
    op_t           op_reg;
    logic [ADDR_W-1:0] dst_reg;
    logic [W-1:0]  out_reg [6];

    logic signed [W:0] ld_v;
    logic [BW-1:0] ld_ext, one_res, mag, neg_mag;
    logic [W-1:0]  ov;
    logic [BW:0]   rem_t, sq_t;
    logic          ge;

    // particle capture
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            if (cmd.cap_first) begin
                fp_reg[i] <= in_data[i*W +: W];
                fx_reg[i] <= in_data[(4+i)*W +: W];
            end
            if (cmd.cap_second) begin
                sp_reg[i] <= in_data[i*W +: W];
                sx_reg[i] <= in_data[(4+i)*W +: W];
            end
        end
    end

    // P, Q and D components
    always_comb begin
        case (cmd.dst[3:2])
            2'd0:    ld_v = {fp_reg[cmd.dst[1:0]][W-1], fp_reg[cmd.dst[1:0]]}
                          + {sp_reg[cmd.dst[1:0]][W-1], sp_reg[cmd.dst[1:0]]};
            2'd1:    ld_v = {fp_reg[cmd.dst[1:0]][W-1], fp_reg[cmd.dst[1:0]]}
                          - {sp_reg[cmd.dst[1:0]][W-1], sp_reg[cmd.dst[1:0]]};
            default: ld_v = {fx_reg[cmd.dst[1:0]][W-1], fx_reg[cmd.dst[1:0]]}
                          - {sx_reg[cmd.dst[1:0]][W-1], sx_reg[cmd.dst[1:0]]};
        endcase
        ld_ext = {{(BW-W-1){ld_v[W]}}, ld_v};
    end

    always_comb begin
        case (cmd.op)
            OP_LOAD: one_res = ld_ext;
            OP_ADD:  one_res = a_reg + b_reg;
            OP_SUB:  one_res = a_reg - b_reg;
            OP_SHL2: one_res = a_reg << 2;
            OP_SHR2: one_res = a_reg >> 2;
            default: one_res = '0;
        endcase
    end

    // saturation and sign of a result field
    always_comb begin
        if (b_reg[BW-1]) begin
            mag = (a_reg > SAT_NEG) ? SAT_NEG : a_reg;
        end else begin
            mag = (a_reg > SAT_POS) ? SAT_POS : a_reg;
        end
        neg_mag = '0 - mag;
        ov = b_reg[BW-1] ? neg_mag[W-1:0] : mag[W-1:0];
    end

    // one step of shift-add multiply, restoring divide or digit square root
    always_comb begin
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        rem_t    = {z_reg[BW-1:0], x_reg[BW-1]};
        sq_t     = z_reg + {1'b0, y_reg};
        ge       = 1'b0;
        iter_res = '0;
        case (op_reg)
            OP_MUL: begin
                z_next   = z_reg + (y_reg[0] ? {1'b0, x_reg} : '0);
                x_next   = x_reg << 1;
                y_next   = y_reg >> 1;
                iter_res = z_next[BW-1:0];
            end
            OP_DIV: begin
                ge       = rem_t >= {1'b0, y_reg};
                z_next   = ge ? rem_t - {1'b0, y_reg} : rem_t;
                x_next   = {x_reg[BW-2:0], ge};
                iter_res = x_next;
            end
            OP_SQRT: begin
                ge       = {1'b0, x_reg} >= sq_t;
                x_next   = ge ? x_reg - sq_t[BW-1:0] : x_reg;
                z_next   = ge ? (z_reg >> 1) + {1'b0, y_reg} : z_reg >> 1;
                y_next   = y_reg >> 2;
                iter_res = z_next[BW-1:0];
            end
            default: begin
                iter_res = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.go) begin
                op_reg  <= cmd.op;
                dst_reg <= cmd.dst;
                case (cmd.op)
                    OP_MUL, OP_DIV: begin
                        busy_reg <= 1'b1;
                        x_reg    <= a_reg;
                        y_reg    <= b_reg;
                        z_reg    <= '0;
                        cnt_reg  <= CNT_FULL;
                    end
                    OP_SQRT: begin
                        busy_reg <= 1'b1;
                        x_reg    <= a_reg;
                        y_reg    <= SQ_ONE;
                        z_reg    <= '0;
                        cnt_reg  <= CNT_HALF;
                    end
                    default: begin
                        res_reg  <= one_res;
                        done_reg <= 1'b1;
                        wr_reg   <= (cmd.op != OP_OUT);
                    end
                endcase
            end else if (busy_reg) begin
                x_reg   <= x_next;
                y_reg   <= y_next;
                z_reg   <= z_next;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    res_reg  <= iter_res;
                    wr_reg   <= 1'b1;
                end
            end
        end
    end

    // operand memory: two registered reads, one write
    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            a_reg <= mem[cmd.ra];
            b_reg <= mem[cmd.rb];
        end
        if (done_reg && wr_reg) begin
            mem[dst_reg] <= res_reg;
        end
    end

    // result fields, zero unless written by the program
    always_ff @(posedge aclk) begin
        if (cmd.cap_second) begin
            for (int i = 0; i < 6; i++) begin
                out_reg[i] <= '0;
            end
        end else if (cmd.go && cmd.op == OP_OUT) begin
            out_reg[cmd.dst[2:0]] <= ov;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.neg  = res_reg[BW-1];
    assign stat.zero = (res_reg == '0);

    assign q_long       = out_reg[0];
    assign q_out        = out_reg[1];
    assign q_side       = out_reg[2];
    assign q_invariant  = out_reg[3][W-2:0];
    assign r_invariant  = out_reg[4][W-2:0];
    assign k_transverse = out_reg[5][W-2:0];

endmodule

@@ rtl/pmd_ctrl.sv @@
// controller: pair sequencing and micro-program stepping
`timescale 1ns / 1ps
`include "pair_momentum_decomposition_top_defines.svh"

module pmd_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  logic           in_second,
    output logic           in_ready,
    input  logic           out_free,
    output logic           emit,
    output logic [1:0]     status,
    output pmd_pkg::cmd_t  cmd,
    input  pmd_pkg::stat_t stat
);
    import pmd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_ISSUE = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            have_first_reg, have_first_next;
    logic [1:0]      status_reg, status_next;
    uword_t          uw;
    logic            fail;

    assign uw       = ucode(pc_reg);
    assign in_ready = (state_reg == ST_IDLE);
    assign status   = status_reg;

    always_comb begin
        case (uw.chk)
            CHK_LE0: fail = stat.neg | stat.zero;
            CHK_LT0: fail = stat.neg;
            CHK_EQ0: fail = stat.zero;
            default: fail = 1'b0;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        have_first_next = have_first_reg;
        status_next     = status_reg;
        emit            = 1'b0;
        cmd             = '0;
        cmd.op          = uw.op;
        cmd.dst         = uw.dst;
        cmd.ra          = uw.ra;
        cmd.rb          = uw.rb;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (!in_second) begin
                        cmd.cap_first   = 1'b1;
                        have_first_next = 1'b1;
                    end else if (have_first_reg) begin
                        cmd.cap_second  = 1'b1;
                        have_first_next = 1'b0;
                        pc_next         = '0;
                        status_next     = STATUS_OK;
                        state_next      = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                if (uw.op == OP_END) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.go     = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (stat.done) begin
                    if (fail) begin
                        status_next = uw.code;
                        state_next  = ST_EMIT;
                    end else begin
                        pc_next    = pc_reg + PC_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pc_reg         <= '0;
            have_first_reg <= 1'b0;
            status_reg     <= STATUS_OK;
        end else begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            have_first_reg <= have_first_next;
            status_reg     <= status_next;
        end
    end

    `PMD_ASSERT_IMP(a_done_in_wait, aclk, aresetn, stat.done, state_reg == ST_WAIT, "unit finished outside wait")
    `PMD_ASSERT_NXT(a_go_starts, aclk, aresetn, cmd.go, stat.busy || stat.done, "issued step did not start")
    `PMD_ASSERT_IMP(a_pc_bound, aclk, aresetn, state_reg == ST_FETCH, pc_reg <= PC_END, "program counter ran past end")
    `PMD_ASSERT_NXT(a_pair_clears, aclk, aresetn, cmd.cap_second, !have_first_reg, "stored first kept after pair")

endmodule

@@ rtl/pair_momentum_decomposition_top.sv @@
// top level of the pair momentum decomposition block
`timescale 1ns / 1ps

// Bertsch-Pratt out/side/long pair decomposition. Particles arrive one per
// input transfer; tuser low stores the particle as first of a pair, tuser
// high completes the pair and yields one result transfer (a second without a
// stored first is dropped). A first particle is only stored. A pair is worked
// by a micro-programmed sequence on one shared bit-serial unit that multiplies,
// divides and takes square roots on 6*VALUE_WIDTH+12 bit words, one bit per
// cycle; a pair takes 39 multiplies, 5 divides and 6 square roots.
// The input is not ready while a pair is worked. A finished result sits in an
// output register, so the next pair may start while it waits. status on
// m_axis_tuser: 0 ok, 1 separation not spacelike, 2 negative qinv squared,
// 3 zero pt or non-positive s; on any error all value fields are zero.

module pair_momentum_decomposition_top #(
    parameter int VALUE_WIDTH = pmd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // p_energy, p_x, p_y, p_z, x_time, x_pos, y_pos, z_pos
    input  logic [((8*VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    // second_of_pair
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // q_long, q_out, q_side, q_invariant, r_invariant, k_transverse
    output logic [((6*VALUE_WIDTH-3+7)/8)*8-1:0]   m_axis_tdata,
    // status
    output logic [1:0]                             m_axis_tuser
);
    import pmd_pkg::*;

    localparam int W      = VALUE_WIDTH;
    localparam int OUT_FW = 6 * W - 3;
    localparam int OUT_TW = ((OUT_FW + 7) / 8) * 8;

    cmd_t  cmd;
    stat_t stat;
    logic  emit, out_free;
    logic [1:0] status;

    logic signed [W-1:0] q_long, q_out, q_side;
    logic [W-2:0]        q_invariant, r_invariant, k_transverse;

    logic              m_tvalid_reg;
    logic [OUT_TW-1:0] m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    // a finished result may move into the output register when it is empty
    // or being taken in this same cycle
    assign out_free = !m_tvalid_reg || m_axis_tready;

    pmd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_second (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_free  (out_free),
        .emit      (emit),
        .status    (status),
        .cmd       (cmd),
        .stat      (stat)
    );

    pmd_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_data      (s_axis_tdata[8*W-1:0]),
        .cmd          (cmd),
        .stat         (stat),
        .q_long       (q_long),
        .q_out        (q_out),
        .q_side       (q_side),
        .q_invariant  (q_invariant),
        .r_invariant  (r_invariant),
        .k_transverse (k_transverse)
    );

    // output register: holds a result until the downstream transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // payload, packed from the lowest bit up, zero padded to whole bytes
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= {{(OUT_TW-OUT_FW){1'b0}}, k_transverse, r_invariant,
                            q_invariant, q_side, q_out, q_long};
            m_tuser_reg <= status;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

endmodule
